// ===== sv/hidkbd_pkg.sv =====
package hidkbd_pkg;

  localparam int NUM_SLOTS   = 6;
  localparam int TABLE_DEPTH = 264;

  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [7:0] KEY_F12     = 8'h45;
  localparam logic [7:0] KEY_ESC     = 8'h29;

  // 8 modifier steps, then a release and a press step per slot
  localparam logic [4:0] FIRST_SLOT_STEP = 5'd8;
  localparam logic [4:0] LAST_STEP       = 5'd19;

  typedef logic [4:0] step_t;

  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_MENU = 2'd1,
    KIND_JOY  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    EV_HIDE   = 4'd0,
    EV_SHOW   = 4'd1,
    EV_DOWN   = 4'd2,
    EV_UP     = 4'd3,
    EV_LEFT   = 4'd4,
    EV_RIGHT  = 4'd5,
    EV_PGDOWN = 4'd6,
    EV_PGUP   = 4'd7,
    EV_SELECT = 4'd8,
    EV_NONE   = 4'd15
  } menu_ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_JOY,
    ST_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic  capture;
    logic  tbl_write;
    logic  look;
    logic  push_direct;
    logic  push_read;
    logic  joy_done;
    logic  flush;
    step_t step;
  } ctl_cmd_t;

  typedef struct packed {
    logic look_direct;
    logic look_read;
    logic rd_emit;
    logic joy_emit;
    logic can_push;
    logic out_free;
    logic pend_valid;
  } dp_status_t;

  function automatic menu_ev_t nav_event(input logic [7:0] c);
    menu_ev_t ev;
    case (c)
      8'h51:        ev = EV_DOWN;
      8'h52:        ev = EV_UP;
      8'h50:        ev = EV_LEFT;
      8'h4f:        ev = EV_RIGHT;
      8'h4e:        ev = EV_PGDOWN;
      8'h4b:        ev = EV_PGUP;
      8'h2c, 8'h28: ev = EV_SELECT;
      default:      ev = EV_NONE;
    endcase
    return ev;
  endfunction

  function automatic logic [7:0] joy_bit(input logic [7:0] c);
    logic [7:0] b;
    case (c)
      8'h5e:   b = 8'h01;
      8'h5c:   b = 8'h02;
      8'h5a:   b = 8'h04;
      8'h60:   b = 8'h08;
      8'h62:   b = 8'h10;
      8'h63:   b = 8'h20;
      8'h44:   b = 8'h40;
      8'h4b:   b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/hid_keyboard_report_to_key_events_unit.sv =====
// channel | direction | handshake            | beat carries
// in      | input     | in_valid / in_ready  | op, modifiers, key_slot_0..5, menu_visible,
//         |           |                      | table_index, table_value
// out     | output    | out_valid / out_ready| kind, value, menu_event, last
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (numpad joystick enable)
//
// A table write beat is taken in idle. A report is taken in idle, then runs 20
// steps (8 modifier bits, release and press per slot), each in the look state,
// plus the read state when the step reads the key table through its registered
// read port, then a joystick and a flush state.
// Reset (rst, synchronous) clears the kept report, joystick byte and enable; the
// key table is not cleared. A stalled output holds the sequencer at its next push.
module hid_keyboard_report_to_key_events_unit
  import hidkbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] modifiers,
  input  logic [7:0] key_slot_0,
  input  logic [7:0] key_slot_1,
  input  logic [7:0] key_slot_2,
  input  logic [7:0] key_slot_3,
  input  logic [7:0] key_slot_4,
  input  logic [7:0] key_slot_5,
  input  logic       menu_visible,
  input  logic [8:0] table_index,
  input  logic [7:0] table_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [3:0] menu_event,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  hidkbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hidkbd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .modifiers    (modifiers),
    .key_slot_0   (key_slot_0),
    .key_slot_1   (key_slot_1),
    .key_slot_2   (key_slot_2),
    .key_slot_3   (key_slot_3),
    .key_slot_4   (key_slot_4),
    .key_slot_5   (key_slot_5),
    .menu_visible (menu_visible),
    .table_index  (table_index),
    .table_value  (table_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .kind         (kind),
    .value        (value),
    .menu_event   (menu_event),
    .last         (last)
  );

endmodule

// ===== sv/hidkbd_ctrl.sv =====
module hidkbd_ctrl
  import hidkbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       op,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t state, state_next;
  step_t      step, step_next;
  logic       at_last;

  assign at_last = (step == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    logic advance;
    advance    = 1'b0;
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !op) begin
          state_next = ST_LOOK;
          step_next  = '0;
        end
      end
      ST_LOOK: begin
        if (status.look_direct) begin
          advance = status.can_push;
        end else if (status.look_read) begin
          state_next = ST_READ;
        end else begin
          advance = 1'b1;
        end
      end
      ST_READ: begin
        advance = !status.rd_emit || status.can_push;
      end
      ST_JOY: begin
        if (!status.joy_emit || status.can_push) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (advance) begin
      if (at_last) begin
        state_next = ST_JOY;
      end else begin
        state_next = ST_LOOK;
        step_next  = step + 5'd1;
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.step = step;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = in_valid && !op;
        cmd.tbl_write = in_valid && op;
      end
      ST_LOOK: begin
        cmd.look        = status.look_read && !status.look_direct;
        cmd.push_direct = status.look_direct && status.can_push;
      end
      ST_READ: begin
        cmd.push_read = status.rd_emit && status.can_push;
      end
      ST_JOY: begin
        cmd.joy_done = !status.joy_emit || status.can_push;
      end
      ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      default: ;
    endcase
  end

  // a new report may only start once the held result has gone out
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !status.pend_valid)
    else $error("pending result left over in idle");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> step <= LAST_STEP)
    else $error("step counter out of range");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> state == ST_IDLE)
    else $error("flush did not end the report");

endmodule

// ===== sv/hidkbd_dp.sv =====
module hidkbd_dp
  import hidkbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ctl_cmd_t   cmd,
  output dp_status_t status,
  input  logic       cfg_valid,
  input  logic       cfg_data,
  input  logic [7:0] modifiers,
  input  logic [7:0] key_slot_0,
  input  logic [7:0] key_slot_1,
  input  logic [7:0] key_slot_2,
  input  logic [7:0] key_slot_3,
  input  logic [7:0] key_slot_4,
  input  logic [7:0] key_slot_5,
  input  logic       menu_visible,
  input  logic [8:0] table_index,
  input  logic [7:0] table_value,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [3:0] menu_event,
  output logic       last
);

  logic       joy_en;
  logic [7:0] cur_mods;
  logic [7:0] cur_slots [NUM_SLOTS];
  logic       vis;
  logic [7:0] prev_mods;
  logic [7:0] prev_slots [NUM_SLOTS];
  logic [7:0] prev_joy;

  logic [7:0] mem [TABLE_DEPTH];
  logic [7:0] rd_data;
  logic [8:0] rd_addr;

  logic       pend_valid;
  kind_t      pend_kind;
  logic [7:0] pend_value;
  menu_ev_t   pend_ev;

  kind_t      out_kind;
  menu_ev_t   out_ev;
  logic [7:0] out_value;

  logic       is_mod;
  logic [2:0] mod_bit;
  logic [4:0] slot_step;
  logic [2:0] slot;
  logic       press;
  logic [7:0] sel_old, sel_cur;
  logic       old_found, cur_found;
  logic       rel;
  menu_ev_t   dir_ev;
  menu_ev_t   nav;
  logic [7:0] joy_now;
  logic       push;
  kind_t      new_kind;
  logic [7:0] new_value;
  menu_ev_t   new_ev;

  assign is_mod    = (cmd.step < FIRST_SLOT_STEP);
  assign mod_bit   = cmd.step[2:0];
  assign slot_step = cmd.step - FIRST_SLOT_STEP;
  assign slot      = slot_step[3:1];
  assign press     = slot_step[0];
  assign sel_old   = prev_slots[slot];
  assign sel_cur   = cur_slots[slot];
  assign nav       = nav_event(sel_cur);

  always_comb begin
    old_found = 1'b0;
    cur_found = 1'b0;
    joy_now   = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (cur_slots[j] == sel_old) old_found = 1'b1;
      if (prev_slots[j] == sel_cur) cur_found = 1'b1;
      joy_now = joy_now | joy_bit(cur_slots[j]);
    end
  end

  // what the current step wants: a table lookup, a direct menu event, or nothing
  always_comb begin
    // a modifier with a zero table entry is never forwarded
    status.rd_emit     = !is_mod || (rd_data != 8'h00);
    status.joy_emit    = joy_en && (joy_now != prev_joy);
    status.out_free    = !out_valid || out_ready;
    status.can_push    = !pend_valid || status.out_free;
    status.pend_valid  = pend_valid;
    status.look_direct = 1'b0;
    status.look_read   = 1'b0;
    rd_addr            = {1'b0, sel_cur};
    rel                = 1'b0;
    dir_ev             = EV_NONE;
    if (is_mod) begin
      status.look_read = !vis && (cur_mods[mod_bit] != prev_mods[mod_bit]);
      rd_addr          = {6'b100000, mod_bit};
      rel              = prev_mods[mod_bit];
    end else if (!press) begin
      status.look_read = (sel_old != 8'h00) && !old_found;
      rd_addr          = {1'b0, sel_old};
      rel              = 1'b1;
    end else if ((sel_cur != 8'h00) && !cur_found) begin
      if (sel_cur == KEY_F12 || (vis && sel_cur == KEY_ESC)) begin
        status.look_direct = 1'b1;
        dir_ev             = vis ? EV_HIDE : EV_SHOW;
      end else if (!vis) begin
        status.look_read = 1'b1;
      end else begin
        status.look_direct = (nav != EV_NONE);
        dir_ev             = nav;
      end
    end
  end

  assign push = cmd.push_direct || cmd.push_read || (cmd.joy_done && status.joy_emit);

  always_comb begin
    new_kind  = KIND_KEY;
    new_value = rel ? (RELEASE_BIT | rd_data) : rd_data;
    new_ev    = EV_HIDE;
    if (cmd.push_direct) begin
      new_kind  = KIND_MENU;
      new_value = 8'h00;
      new_ev    = dir_ev;
    end else if (cmd.joy_done) begin
      new_kind  = KIND_JOY;
      new_value = joy_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_write && (table_index < 9'(TABLE_DEPTH))) mem[table_index] <= table_value;
    if (cmd.look) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_mods     <= modifiers;
      cur_slots[0] <= key_slot_0;
      cur_slots[1] <= key_slot_1;
      cur_slots[2] <= key_slot_2;
      cur_slots[3] <= key_slot_3;
      cur_slots[4] <= key_slot_4;
      cur_slots[5] <= key_slot_5;
      vis          <= menu_visible;
    end
    if (push) begin
      pend_kind  <= new_kind;
      pend_value <= new_value;
      pend_ev    <= new_ev;
    end
    if ((push && pend_valid) || cmd.flush) begin
      out_kind  <= pend_kind;
      out_value <= pend_value;
      out_ev    <= pend_ev;
      last      <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joy_en     <= 1'b0;
      prev_mods  <= '0;
      prev_joy   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) prev_slots[i] <= '0;
    end else begin
      if (cfg_valid) joy_en <= cfg_data;
      if (cmd.joy_done) begin
        prev_mods <= cur_mods;
        for (int i = 0; i < NUM_SLOTS; i++) prev_slots[i] <= cur_slots[i];
        if (status.joy_emit) prev_joy <= joy_now;
      end
      if (push) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if ((push && pend_valid) || cmd.flush) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign kind       = out_kind;
  assign value      = out_value;
  assign menu_event = out_ev;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push && pend_valid |-> status.out_free)
    else $error("held result pushed onto a busy output");

  a_flush_room: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> pend_valid && status.out_free && !push)
    else $error("flush without a held result or room");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> out_valid && last && !pend_valid)
    else $error("final beat not marked last");

endmodule
